[hdl/ubd_pkg.sv]
// Shared types, constants and the alphabet lookup for the base64url payload decoder.
// No dependencies; used by every module of the block.
`default_nettype none

package ubd_pkg;

    // Configuration register file
    localparam int unsigned PADDR_W        = 3;
    localparam int unsigned PDATA_W        = 32;
    localparam logic        REG_TERM_COUNT = 1'b0;   // register index, paddr[2]
    localparam logic [1:0]  TERM_COUNT_RST = 2'd2;
    localparam logic [1:0]  TERM_COUNT_MAX = 2'd2;

    // Command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // Results one character can cause
    localparam int unsigned MAX_RESULTS = 4;

    // Alphabet offsets
    localparam logic [5:0] LOWER_BASE = 6'd26;
    localparam logic [5:0] DIGIT_BASE = 6'd52;
    localparam logic [5:0] CODE_DASH  = 6'd62;
    localparam logic [5:0] CODE_UNDER = 6'd63;

    // Characters of the scheme separator
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // One queued command: the results of one character, in order
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [2:0]                  count;    // 1 .. MAX_RESULTS
        logic                        missing;  // no-prefix status result
        logic                        last;     // final result carries tlast
    } cmd_t;

    // Sextet lookup: bit 6 set means the character is outside the alphabet
    function automatic logic [6:0] sextet_of(input logic [7:0] ch);
        logic [6:0] res;
        res = 7'h40;
        if (ch >= 8'h41 && ch <= 8'h5A)
            res = {1'b0, ch[5:0] - 6'h01};
        else if (ch >= 8'h61 && ch <= 8'h7A)
            res = {1'b0, ch[5:0] - 6'h21 + LOWER_BASE};
        else if (ch >= 8'h30 && ch <= 8'h39)
            res = {1'b0, ch[5:0] - 6'h30 + DIGIT_BASE};
        else if (ch == 8'h2D)
            res = {1'b0, CODE_DASH};
        else if (ch == 8'h5F)
            res = {1'b0, CODE_UNDER};
        return res;
    endfunction

endpackage

`default_nettype wire

[hdl/ubd_front.sv]
// Front part: accepts characters, tracks the scheme separator and the bit accumulator,
// and builds one command per character that causes results. Depends on ubd_pkg.
`default_nettype none

module ubd_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        in_char,
    input  wire logic              in_last,
    input  wire logic [1:0]        term_count,
    input  wire logic              queue_full,
    output logic                   push,
    output ubd_pkg::cmd_t          push_cmd
);

    logic       sep_found_reg,  sep_found_next;
    logic       after_colon_reg, after_colon_next;
    logic [1:0] slash_cnt_reg,  slash_cnt_next;
    logic [2:0] held_cnt_reg,   held_cnt_next;
    logic [5:0] held_bits_reg,  held_bits_next;

    logic       accept;
    logic [6:0] sextet;
    logic       pay_valid;
    logic [7:0] pay_byte;
    logic       flush_valid;
    logic [7:0] flush_byte;
    logic [1:0] terms;
    logic [1:0] slash_inc;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign sextet   = ubd_pkg::sextet_of(in_char);
    assign slash_inc = slash_cnt_reg + 2'd1;

    // Separator search and bit accumulator
    always_comb
    begin
        sep_found_next   = sep_found_reg;
        after_colon_next = after_colon_reg;
        slash_cnt_next   = slash_cnt_reg;
        held_cnt_next    = held_cnt_reg;
        held_bits_next   = held_bits_reg;
        pay_valid        = 1'b0;
        pay_byte         = 8'd0;
        if (!sep_found_reg)
        begin
            if (in_char == ubd_pkg::CH_COLON)
            begin
                slash_cnt_next   = 2'd0;
                after_colon_next = 1'b1;
            end
            else if (in_char == ubd_pkg::CH_SLASH)
            begin
                if (after_colon_reg || slash_cnt_reg != 2'd0)
                begin
                    slash_cnt_next = slash_inc;
                    if (slash_inc == 2'd2)
                        sep_found_next = 1'b1;
                end
                after_colon_next = 1'b0;
            end
            else
            begin
                after_colon_next = 1'b0;
                slash_cnt_next   = 2'd0;
            end
        end
        else if (!sextet[6])
        begin
            case (held_cnt_reg)
                3'd2:
                begin
                    pay_valid      = 1'b1;
                    pay_byte       = {held_bits_reg[1:0], sextet[5:0]};
                    held_bits_next = 6'd0;
                    held_cnt_next  = 3'd0;
                end
                3'd4:
                begin
                    pay_valid      = 1'b1;
                    pay_byte       = {held_bits_reg[3:0], sextet[5:2]};
                    held_bits_next = {4'd0, sextet[1:0]};
                    held_cnt_next  = 3'd2;
                end
                3'd6:
                begin
                    pay_valid      = 1'b1;
                    pay_byte       = {held_bits_reg, sextet[5:4]};
                    held_bits_next = {2'd0, sextet[3:0]};
                    held_cnt_next  = 3'd4;
                end
                default:
                begin
                    held_bits_next = sextet[5:0];
                    held_cnt_next  = 3'd6;
                end
            endcase
        end
    end

    // Leftover bits, left-aligned, as the flush byte
    always_comb
    begin
        flush_valid = 1'b1;
        case (held_cnt_next)
            3'd2:    flush_byte = {held_bits_next[1:0], 6'd0};
            3'd4:    flush_byte = {held_bits_next[3:0], 4'd0};
            3'd6:    flush_byte = {held_bits_next, 2'd0};
            default:
            begin
                flush_valid = 1'b0;
                flush_byte  = 8'd0;
            end
        endcase
    end

    assign terms = (term_count > ubd_pkg::TERM_COUNT_MAX) ? ubd_pkg::TERM_COUNT_MAX
                                                          : term_count;

    // Assemble the command; terminators are the zero bytes behind the data
    always_comb
    begin
        push_cmd       = '0;
        push_cmd.last  = in_last;
        if (!in_last)
        begin
            push_cmd.bytes[0] = pay_byte;
            push_cmd.count    = {2'd0, pay_valid};
        end
        else if (!sep_found_next)
        begin
            push_cmd.missing = 1'b1;
            push_cmd.count   = 3'd1;
        end
        else
        begin
            push_cmd.bytes[0] = pay_valid ? pay_byte : flush_byte;
            push_cmd.bytes[1] = (pay_valid && flush_valid) ? flush_byte : 8'd0;
            push_cmd.count    = {2'd0, pay_valid} + {2'd0, flush_valid} + {1'b0, terms};
        end
    end

    assign push = accept && (push_cmd.count != 3'd0);

    // Advance the stream state; clear it after the final character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_found_reg   <= 1'b0;
            after_colon_reg <= 1'b0;
            slash_cnt_reg   <= 2'd0;
            held_cnt_reg    <= 3'd0;
            held_bits_reg   <= 6'd0;
        end
        else if (accept)
        begin
            if (in_last)
            begin
                sep_found_reg   <= 1'b0;
                after_colon_reg <= 1'b0;
                slash_cnt_reg   <= 2'd0;
                held_cnt_reg    <= 3'd0;
                held_bits_reg   <= 6'd0;
            end
            else
            begin
                sep_found_reg   <= sep_found_next;
                after_colon_reg <= after_colon_next;
                slash_cnt_reg   <= slash_cnt_next;
                held_cnt_reg    <= held_cnt_next;
                held_bits_reg   <= held_bits_next;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/ubd_queue.sv]
// Short command queue between the front and back parts of the decoder.
// Depends on ubd_pkg for the command type.
`default_nettype none

module ubd_queue #(
    parameter int unsigned Depth = ubd_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ubd_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output ubd_pkg::cmd_t      head,
    output logic               empty,
    output logic               full
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    ubd_pkg::cmd_t   entry_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] fill_reg,   fill_next;

    assign empty = (fill_reg == '0);
    assign full  = (fill_reg == FullCnt);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PtrW'(1);
        rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PtrW'(1);
        fill_next   = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + CntW'(1);
        else if (pop && !push)
            fill_next = fill_reg - CntW'(1);
    end

    // Store incoming commands
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
            fill_reg <= fill_next;
        end
    end

endmodule

`default_nettype wire

[hdl/ubd_back.sv]
// Back part: walks the results of the command at the queue head, one a cycle
// while not stalled, into the output register. Depends on ubd_pkg.
`default_nettype none

module ubd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ubd_pkg::cmd_t head,
    input  wire logic          empty,
    output logic               pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [7:0]         out_byte,
    output logic               prefix_missing,
    output logic               out_last
);

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_missing_reg;
    logic       out_last_reg;

    logic       slot_free;
    logic       emit;
    logic       final_slot;

    assign slot_free  = !out_valid_reg || m_tready;
    assign emit       = slot_free && !empty;
    assign final_slot = (({1'b0, idx_reg}) + 3'd1) == head.count;
    assign pop        = emit && final_slot;

    // Step through the results of the head command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
                idx_reg <= final_slot ? 2'd0 : idx_reg + 2'd1;
            if (slot_free)
                out_valid_reg <= emit;
        end
    end

    // Hold the output payload until the transfer completes
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg    <= head.bytes[idx_reg];
            out_missing_reg <= head.missing;
            out_last_reg    <= head.last && final_slot;
        end
    end

    assign m_tvalid       = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign prefix_missing = out_missing_reg;
    assign out_last       = out_last_reg;

endmodule

`default_nettype wire

[hdl/url_payload_base64url_decoder.sv]
// Top level of the base64url payload decoder: configuration registers and the
// front, queue and back parts. Depends on ubd_pkg, ubd_front, ubd_queue, ubd_back.
//
//   Channel  Direction  Carries
//   s_*      in         one character, tlast on the final character of a string
//   m_*      out        decoded byte, flush byte, terminator or no-prefix status
//   APB      in/out     terminator_count at byte address 0
//
// One character is accepted every cycle while the command queue has room.
// The back part delivers one result per cycle while m_tready does not stall it;
// only the final character of a string gives a burst of up to four results, absorbed by the command queue.
// A character's first result passes the queue entry, then the output register.
// Reset is asynchronous; terminator_count returns to 2 and no clearing pass runs.
// A stalled output holds its transfer; the queue fills and then drops s_tready.
`default_nettype none

module url_payload_base64url_decoder #(
    parameter int unsigned QueueDepth = ubd_pkg::QUEUE_DEPTH
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // Input characters
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // [7:0] in_char
    input  wire logic                        s_tlast,
    // Results
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [7:0]                       m_tdata,   // [7:0] out_byte
    output logic                             m_tuser,   // [0] prefix_missing
    output logic                             m_tlast,
    // Configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ubd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [ubd_pkg::PDATA_W-1:0] pwdata,
    output logic [ubd_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);

    logic [1:0]    term_count_reg;
    logic          cfg_write;
    logic          queue_full;
    logic          queue_empty;
    logic          push;
    logic          pop;
    ubd_pkg::cmd_t push_cmd;
    ubd_pkg::cmd_t head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            term_count_reg <= ubd_pkg::TERM_COUNT_RST;
        else if (cfg_write && paddr[2] == ubd_pkg::REG_TERM_COUNT)
            term_count_reg <= pwdata[1:0];
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == ubd_pkg::REG_TERM_COUNT)
            prdata = {{(ubd_pkg::PDATA_W-2){1'b0}}, term_count_reg};
    end

    ubd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_char    (s_tdata),
        .in_last    (s_tlast),
        .term_count (term_count_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    ubd_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    ubd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .empty          (queue_empty),
        .pop            (pop),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .out_byte       (m_tdata),
        .prefix_missing (m_tuser),
        .out_last       (m_tlast)
    );

endmodule

`default_nettype wire

[hdl/ubd_checker.sv]
// Port-level checks for the base64url payload decoder, bound to the top level.
// Depends on ubd_pkg and url_payload_base64url_decoder.
`default_nettype none

module ubd_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [7:0]                  m_tdata,
    input wire logic                        m_tuser,
    input wire logic                        m_tlast,
    input wire logic [ubd_pkg::PDATA_W-1:0] prdata
);

    // A stalled result transfer holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast))
        else $error("stalled result changed");

    // The no-prefix status is a single zero result that closes the string
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && m_tdata == 8'd0)
        else $error("malformed no-prefix status");

    // An offered result is always fully known
    assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(m_tvalid) && (!m_tvalid || !$isunknown({m_tdata, m_tuser, m_tlast})))
        else $error("unknown result bits");

    // Only the two-bit register reads back
    assert property (@(posedge clk) disable iff (!rst_n)
        prdata[ubd_pkg::PDATA_W-1:2] == '0)
        else $error("unused read data bits set");

endmodule

bind url_payload_base64url_decoder ubd_checker u_ubd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .prdata   (prdata)
);

`default_nettype wire
